FILE: hdl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; imported by the top level and its checker.
package dq_pkg;

  typedef logic signed [31:0] elem_t;
  typedef logic [2:0]         action_t;
  typedef logic [1:0]         status_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_LIST       = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

FILE: hdl/double_ended_queue.sv
// Double-ended queue top level: ring store in a synchronous memory,
// head pointer and element count in registers. Depends on dq_pkg.
// A push or pop result is presented the cycle after its item is accepted. A list item
// passes the state register, the read into rd_data and the output register, then one
// element per cycle while the output is taken; the single memory read port sets this pace.
// Throughput: one push/pop item per cycle while output drains; a list holds the input to its end.
// Reset clears head, count, state and output valid; the ring memory is not cleared.
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  dq_pkg::elem_t   s_axis_tdata,  // [31:0] value
  input  dq_pkg::action_t s_axis_tuser,  // [2:0] action
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output dq_pkg::elem_t   m_axis_tdata,  // [31:0] element
  output dq_pkg::status_t m_axis_tuser,  // [1:0] status
  output logic          m_axis_tlast
);
  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  function automatic logic [AW-1:0] pos_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] pos_prev(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  logic [31:0]   mem [DEPTH];
  elem_t         rd_data;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          state;
  logic [AW-1:0] rd_pos;
  logic [CW-1:0] remaining;
  logic          pend;
  logic          pend_last;

  logic          out_valid;
  elem_t         out_elem;
  status_t       out_status;
  logic          out_last;

  logic          out_free;
  logic          out_set;
  logic          accept;
  logic          full;
  logic          empty;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic          load;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count == CW'(DEPTH));
  assign empty         = (count == '0);

  assign load  = (state == ST_LIST) && pend && out_free;
  assign rd_en = (state == ST_LIST) && (remaining != '0) && (!pend || load);

  // a new result enters the output register this cycle
  assign out_set = load ||
                   (accept && ((s_axis_tuser inside {ACT_PUSH_FRONT, ACT_PUSH_BACK,
                                                     ACT_POP_FRONT, ACT_POP_BACK}) ||
                               (s_axis_tuser == ACT_LIST && empty)));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_prev(head);
    if (accept && !full) begin
      case (s_axis_tuser)
        ACT_PUSH_FRONT: begin
          wr_en   = 1'b1;
          wr_addr = pos_prev(head);
        end
        ACT_PUSH_BACK: begin
          wr_en   = 1'b1;
          wr_addr = ring_pos(head, count[AW-1:0]);
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= s_axis_tdata;
    if (rd_en) rd_data <= mem[rd_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      state     <= ST_IDLE;
      rd_pos    <= '0;
      remaining <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_axis_tready && !out_set) out_valid <= 1'b0;

      if (accept) begin
        case (s_axis_tuser)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            out_valid  <= 1'b1;
            out_elem   <= '0;
            out_last   <= 1'b1;
            out_status <= full ? ST_FULL : ST_OK;
            if (!full) begin
              count <= count + CW'(1);
              if (s_axis_tuser == ACT_PUSH_FRONT) head <= pos_prev(head);
            end
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            out_valid  <= 1'b1;
            out_elem   <= '0;
            out_last   <= 1'b1;
            out_status <= empty ? ST_EMPTY : ST_OK;
            if (!empty) begin
              count <= count - CW'(1);
              if (s_axis_tuser == ACT_POP_FRONT) head <= pos_next(head);
            end
          end
          ACT_LIST: begin
            if (empty) begin
              out_valid  <= 1'b1;
              out_elem   <= '0;
              out_last   <= 1'b1;
              out_status <= ST_EMPTY;
            end else begin
              state     <= ST_LIST;
              rd_pos    <= head;
              remaining <= count;
              pend      <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (state == ST_LIST) begin
        // read data is held in rd_data until it moves to the output register
        if (load) begin
          out_valid  <= 1'b1;
          out_elem   <= rd_data;
          out_status <= ST_OK;
          out_last   <= pend_last;
          if (pend_last) state <= ST_IDLE;
        end
        if (rd_en) begin
          rd_pos    <= pos_next(rd_pos);
          remaining <= remaining - CW'(1);
          pend_last <= (remaining == CW'(1));
          pend      <= 1'b1;
        end else if (load) begin
          pend <= 1'b0;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_elem;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

FILE: hdl/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue.
module dq_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input dq_pkg::elem_t   s_axis_tdata,
  input dq_pkg::action_t s_axis_tuser,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input dq_pkg::elem_t   m_axis_tdata,
  input dq_pkg::status_t m_axis_tuser,
  input logic          m_axis_tlast
);
  import dq_pkg::*;

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // input is only taken when the output slot can take the answer
  a_slot: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input ready while output blocked");

  // push and pop answer in the next cycle with a single final item
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tuser == ACT_PUSH_FRONT || s_axis_tuser == ACT_PUSH_BACK ||
     s_axis_tuser == ACT_POP_FRONT  || s_axis_tuser == ACT_POP_BACK)
    |=> m_axis_tvalid && m_axis_tlast && m_axis_tdata == '0)
    else $error("push/pop result missing or malformed");

  // refusals and empty lists carry no element and close the run
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0 && m_axis_tlast)
    else $error("non-ok result with element or without last");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: stream driver, stream monitor and
// a cycle-free predictor of the ring deque. Depends on dq_pkg and the RTL top level.
module testbench;
  import dq_pkg::*;

  localparam int QDEPTH = 64;
  localparam int RANDOM_ITEMS = 320;

  typedef struct {
    action_t     act;
    elem_t       val;
    int unsigned gap_after;
  } cmd_item_t;

  typedef struct {
    elem_t   element;
    status_t status;
    logic    last;
  } deque_result_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} walk_phase_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  elem_t           s_axis_tdata = '0;   // [31:0] value
  action_t         s_axis_tuser = '0;   // [2:0] action
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  elem_t           m_axis_tdata;        // [31:0] element
  status_t         m_axis_tuser;        // [1:0] status
  logic            m_axis_tlast;

  cmd_item_t       pending_cmds[$];
  deque_result_t   expected_results[$];
  int unsigned     total_cmds = 0;
  int unsigned     accepted_cmds = 0;
  int unsigned     mismatch_count = 0;

  // Predictor state
  elem_t           ring_mem [QDEPTH];
  logic [5:0]      front_pos = '0;
  logic [6:0]      fill_level = '0;

  double_ended_queue #(.DEPTH(QDEPTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int unsigned idle_cycles(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic elem_t rand_value();
    case ($urandom_range(0, 15))
      0: return elem_t'(32'h8000_0000);
      1: return elem_t'(32'h7fff_ffff);
      2: return '0;
      3: return '1;
      default: return elem_t'($urandom);
    endcase
  endfunction

  task automatic queue_result(elem_t element, status_t status, logic last);
    deque_result_t r;
    r.element = element;
    r.status  = status;
    r.last    = last;
    expected_results.insert(expected_results.size(), r);
  endtask

  // Works out the results of one accepted item and updates the deque copy.
  task automatic apply_action(action_t act, elem_t val);
    logic [5:0] slot;
    int unsigned k;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_level >= QDEPTH) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            front_pos = front_pos - 6'd1;
            ring_mem[front_pos] = val;
          end else begin
            slot = front_pos + fill_level[5:0];
            ring_mem[slot] = val;
          end
          fill_level = fill_level + 7'd1;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill_level == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) front_pos = front_pos + 6'd1;
          fill_level = fill_level - 7'd1;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      ACT_LIST: begin
        if (fill_level == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (k = 0; k < fill_level; k++) begin
            slot = front_pos + 6'(k);
            queue_result(ring_mem[slot], ST_OK, (k + 1 == fill_level));
          end
        end
      end
      default: ;  // unused codes are dropped silently
    endcase
  endtask

  task automatic add_cmd(action_t act, elem_t val, int unsigned gap);
    cmd_item_t c;
    c.act       = act;
    c.val       = val;
    c.gap_after = gap;
    pending_cmds.insert(pending_cmds.size(), c);
    total_cmds++;
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Source side
  int unsigned src_gap = 0;
  cmd_item_t   next_cmd;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_action(s_axis_tuser, s_axis_tdata);
        accepted_cmds++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds[0];
          pending_cmds.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_cmd.act;
          s_axis_tdata  <= next_cmd.val;
          src_gap = next_cmd.gap_after;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: ready stalls, with calm stretches where it stays high
  int unsigned sink_stall = 0;
  bit          sink_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 59) == 0) sink_calm = !sink_calm;
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) sink_stall = idle_cycles(sink_calm);
      end
    end
  end

  // Result checker
  deque_result_t want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item: element %0d status %0d last %0b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (m_axis_tdata !== want.element || m_axis_tuser !== want.status ||
            m_axis_tlast !== want.last)
          report_mismatch($sformatf(
            "got element %0d status %0d last %0b, want element %0d status %0d last %0b",
            m_axis_tdata, m_axis_tuser, m_axis_tlast,
            want.element, want.status, want.last));
      end
    end
  end

  initial begin
    walk_phase_t phase;
    int          gen_count;
    int          mix_left;
    int          calm_left;
    bit          calm;
    int unsigned r;
    int unsigned n;
    action_t     act;

    // Directed: empty cases, extreme values, front wrap, every action, unused codes
    add_cmd(ACT_LIST,       '0, 0);
    add_cmd(ACT_POP_FRONT,  '0, 0);
    add_cmd(ACT_POP_BACK,   '1, 2);
    add_cmd(ACT_PUSH_BACK,  elem_t'(32'h7fff_ffff), 0);
    add_cmd(ACT_PUSH_FRONT, elem_t'(32'h8000_0000), 0);
    add_cmd(ACT_PUSH_BACK,  '1, 1);
    add_cmd(ACT_PUSH_FRONT, '0, 0);
    add_cmd(ACT_LIST,       elem_t'(32'h5555_5555), 0);
    add_cmd(action_t'(3'd5), elem_t'(32'h1234_5678), 0);
    add_cmd(action_t'(3'd6), '1, 3);
    add_cmd(action_t'(3'd7), '0, 0);
    add_cmd(ACT_POP_BACK,   '0, 0);
    add_cmd(ACT_POP_FRONT,  '0, 0);
    add_cmd(ACT_LIST,       '0, 0);
    add_cmd(ACT_PUSH_BACK,  elem_t'(32'h5555_5555), 0);
    add_cmd(ACT_PUSH_FRONT, elem_t'(32'haaaa_aaaa), 0);
    add_cmd(ACT_LIST,       '0, 5);
    gen_count = 4;

    // Random walk: fill to full and beyond, drain to empty and beyond, mixed spells
    phase     = PH_FILL;
    mix_left  = 0;
    calm_left = 0;
    calm      = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (calm_left == 0) begin
        calm = !calm;
        calm_left = $urandom_range(8, 40);
      end
      calm_left--;
      r = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  act = (r < 88) ? ($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK) :
                        (r < 93) ? ($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK) :
                        (r < 97) ? ACT_LIST : action_t'($urandom_range(5, 7));
        PH_DRAIN: act = (r < 86) ? ($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK) :
                        (r < 91) ? ($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK) :
                        (r < 97) ? ACT_LIST : action_t'($urandom_range(5, 7));
        default:  act = (r < 40) ? ($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK) :
                        (r < 80) ? ($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK) :
                        (r < 93) ? ACT_LIST : action_t'($urandom_range(5, 7));
      endcase
      add_cmd(act, rand_value(), idle_cycles(calm));

      if ((act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) && gen_count < QDEPTH)
        gen_count++;
      else if ((act == ACT_POP_FRONT || act == ACT_POP_BACK) && gen_count > 0)
        gen_count--;

      case (phase)
        PH_FILL: if (gen_count == QDEPTH && $urandom_range(0, 3) == 0) phase = PH_DRAIN;
        PH_DRAIN: begin
          if (gen_count == 0 && $urandom_range(0, 2) == 0) begin
            phase = PH_MIX;
            mix_left = $urandom_range(10, 30);
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) phase = PH_FILL;
        end
      endcase
    end

    while (rst) @(posedge clk);
    while (accepted_cmds < total_cmds) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
hdl/dq_pkg.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
tb/testbench.sv
